### rtl/core/rrb_pkg.sv
// shared types and constants for the rotated rectangle bounds core
package rrb_pkg;

  // field widths of the coordinate and size payloads
  localparam int COORD_W = 24;
  localparam int SIZE_W  = 23;

  // default parameter values for the top level
  localparam int DEF_ANGLE_BITS = 16;
  localparam int DEF_TRIG_BITS  = 16;

  // taylor series in q30: pi/2, one, and the number of terms after the first
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int          TERM_STEPS  = 13;
  localparam int          THETA_W     = 31;
  localparam int          X_W         = 32;
  localparam int          ACC_W       = 34;
  localparam logic signed [ACC_W-1:0] ACC_ONE = 34'sd1073741824;

  // corner offset width: coordinate plus size minus pivot
  localparam int DX_W = 26;

  // saturation limits of the result fields
  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;
  localparam int SIZE_MAX  = 8388607;

  // quadrant of the turn angle
  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,
    QUAD_SECOND = 2'd1,
    QUAD_THIRD  = 2'd2,
    QUAD_FOURTH = 2'd3
  } quad_t;

  // rectangle and pivot carried alongside the angle math
  typedef struct packed {
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic        [SIZE_W-1:0]  rect_width;
    logic        [SIZE_W-1:0]  rect_height;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
  } geom_t;

  // per-stage context of the sine/cosine series
  typedef struct packed {
    quad_t                   quad;
    logic [THETA_W-1:0]      theta;
    logic signed [ACC_W-1:0] s_acc;
    logic signed [ACC_W-1:0] c_acc;
    geom_t                   geom;
  } ctx_t;

  // one result transaction
  typedef struct packed {
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic        [SIZE_W-1:0]  box_width;
    logic        [SIZE_W-1:0]  box_height;
  } box_t;

endpackage

### rtl/core/rrb_in_if.sv
// input channel carrying the rectangle, angle and pivot
interface rrb_in_if #(
  parameter int ANGLE_BITS = rrb_pkg::DEF_ANGLE_BITS
);
  logic                              valid;
  logic                              ready;
  logic signed [rrb_pkg::COORD_W-1:0] rect_left;
  logic signed [rrb_pkg::COORD_W-1:0] rect_top;
  logic        [rrb_pkg::SIZE_W-1:0]  rect_width;
  logic        [rrb_pkg::SIZE_W-1:0]  rect_height;
  logic        [ANGLE_BITS-1:0]       turn_angle;
  logic signed [rrb_pkg::COORD_W-1:0] pivot_x;
  logic signed [rrb_pkg::COORD_W-1:0] pivot_y;

  modport source (
    output valid, rect_left, rect_top, rect_width, rect_height, turn_angle, pivot_x, pivot_y,
    input  ready
  );

  modport sink (
    input  valid, rect_left, rect_top, rect_width, rect_height, turn_angle, pivot_x, pivot_y,
    output ready
  );
endinterface

### rtl/core/rrb_out_if.sv
// output channel carrying the bounding box
interface rrb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rrb_pkg::COORD_W-1:0] box_left;
  logic signed [rrb_pkg::COORD_W-1:0] box_top;
  logic        [rrb_pkg::SIZE_W-1:0]  box_width;
  logic        [rrb_pkg::SIZE_W-1:0]  box_height;

  modport source (
    output valid, box_left, box_top, box_width, box_height,
    input  ready
  );

  modport sink (
    input  valid, box_left, box_top, box_width, box_height,
    output ready
  );
endinterface

### rtl/core/rrb_trig.sv
// pipelined sine/cosine of a binary angle by a fixed-point taylor series
module rrb_trig #(
  parameter int ANGLE_BITS = rrb_pkg::DEF_ANGLE_BITS,
  parameter int TRIG_BITS  = rrb_pkg::DEF_TRIG_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [ANGLE_BITS-1:0]     angle,
  input  rrb_pkg::geom_t            in_geom,
  output logic                      out_valid,
  output logic signed [TRIG_BITS+1:0] sin_val,
  output logic signed [TRIG_BITS+1:0] cos_val,
  output rrb_pkg::geom_t            out_geom
);

  localparam int STEPS = rrb_pkg::TERM_STEPS;
  localparam int SH    = 30 - TRIG_BITS;
  localparam logic [rrb_pkg::ACC_W-1:0] T_ONE  = 34'd1 << TRIG_BITS;
  localparam logic [rrb_pkg::ACC_W-1:0] T_HALF = 34'd1 << (SH - 1);

  // add one series term into sine (odd index) or cosine (even index)
  function automatic rrb_pkg::ctx_t add_term(input rrb_pkg::ctx_t ctx,
                                             input logic [rrb_pkg::THETA_W-1:0] term,
                                             input logic [3:0] idx);
    rrb_pkg::ctx_t r;
    logic signed [rrb_pkg::ACC_W-1:0] d;
    r = ctx;
    d = $signed({3'b000, term});
    if (idx[1]) begin
      d = -d;
    end
    if (idx[0]) begin
      r.s_acc = r.s_acc + d;
    end else begin
      r.c_acc = r.c_acc + d;
    end
    return r;
  endfunction

  // round half up to trig precision, clamp to zero and one
  function automatic logic [TRIG_BITS:0] trig_round(input logic signed [rrb_pkg::ACC_W-1:0] v);
    logic [rrb_pkg::ACC_W-1:0] sum;
    logic [rrb_pkg::ACC_W-1:0] shifted;
    sum     = (v[rrb_pkg::ACC_W-1] ? '0 : v) + T_HALF;
    shifted = sum >> SH;
    if (shifted > T_ONE) begin
      return T_ONE[TRIG_BITS:0];
    end
    return shifted[TRIG_BITS:0];
  endfunction

  rrb_pkg::ctx_t                 t_ctx   [STEPS+1];
  logic [rrb_pkg::THETA_W-1:0]   t_term  [STEPS+1];
  logic                          t_valid [STEPS+1];
  rrb_pkg::ctx_t                 m_ctx   [STEPS];
  logic [rrb_pkg::X_W-1:0]       m_x     [STEPS];
  logic                          m_valid [STEPS];
  rrb_pkg::ctx_t                 q_ctx   [STEPS];
  logic [rrb_pkg::X_W-1:0]       q_x     [STEPS];
  logic [rrb_pkg::X_W-1:0]       q_qe    [STEPS];
  logic                          q_valid [STEPS];

  // angle to quadrant and q30 fraction of a quarter turn, scaled by pi/2
  logic [29:0] u;
  logic [60:0] theta_prod;
  assign u          = {angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
  assign theta_prod = {31'b0, u} * {30'b0, rrb_pkg::HALF_PI_Q30};

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid[0] <= 1'b0;
    end else if (adv) begin
      t_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_ctx[0].quad  <= rrb_pkg::quad_t'(angle[ANGLE_BITS-1:ANGLE_BITS-2]);
      t_ctx[0].theta <= theta_prod[60:30];
      t_ctx[0].s_acc <= $signed({3'b000, theta_prod[60:30]});
      t_ctx[0].c_acc <= rrb_pkg::ACC_ONE;
      t_ctx[0].geom  <= in_geom;
      t_term[0]      <= theta_prod[60:30];
    end
  end

  // one term per step: multiply by theta, divide by the term index, correct
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int N  = j + 2;
    localparam int NP = j + 1;
    localparam logic [rrb_pkg::X_W-1:0] RECIP = 32'((64'd1 << 32) / N);
    localparam logic [rrb_pkg::X_W-1:0] DIV   = 32'(N);

    logic [61:0]                 m_prod;
    rrb_pkg::ctx_t               m_ctx_next;
    logic [63:0]                 q_prod;
    logic [rrb_pkg::X_W-1:0]     c_rem;
    logic [rrb_pkg::THETA_W-1:0] c_term;

    // multiply stage, also folding the previous term into its sum from the second step on
    assign m_prod = {31'b0, t_term[j]} * {31'b0, t_ctx[j].theta};

    always_comb begin
      if (NP > 1) begin
        m_ctx_next = add_term(t_ctx[j], t_term[j], 4'(NP));
      end else begin
        m_ctx_next = t_ctx[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        m_valid[j] <= 1'b0;
      end else if (adv) begin
        m_valid[j] <= t_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        m_ctx[j] <= m_ctx_next;
        m_x[j]   <= m_prod[61:30];
      end
    end

    // reciprocal multiply, quotient low by at most one
    assign q_prod = {32'b0, m_x[j]} * {32'b0, RECIP};

    always_ff @(posedge clk) begin
      if (rst) begin
        q_valid[j] <= 1'b0;
      end else if (adv) begin
        q_valid[j] <= m_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_ctx[j] <= m_ctx[j];
        q_x[j]   <= m_x[j];
        q_qe[j]  <= q_prod[63:32];
      end
    end

    // remainder check fixes the quotient
    assign c_rem  = q_x[j] - 32'(q_qe[j] * DIV);
    assign c_term = (c_rem >= DIV) ? 31'(q_qe[j][30:0] + 31'd1) : q_qe[j][30:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        t_valid[j+1] <= 1'b0;
      end else if (adv) begin
        t_valid[j+1] <= q_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        t_ctx[j+1]  <= q_ctx[j];
        t_term[j+1] <= c_term;
      end
    end
  end

  // last term folded in
  rrb_pkg::ctx_t f_ctx;
  logic          f_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= t_valid[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_ctx <= add_term(t_ctx[STEPS], t_term[STEPS], 4'(STEPS + 1));
    end
  end

  // rounding to trig precision
  logic [TRIG_BITS:0] g_sv;
  logic [TRIG_BITS:0] g_cv;
  rrb_pkg::quad_t     g_quad;
  rrb_pkg::geom_t     g_geom;
  logic               g_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (adv) begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_sv   <= trig_round(f_ctx.s_acc);
      g_cv   <= trig_round(f_ctx.c_acc);
      g_quad <= f_ctx.quad;
      g_geom <= f_ctx.geom;
    end
  end

  // quadrant placement
  logic signed [TRIG_BITS+1:0] sv_pos;
  logic signed [TRIG_BITS+1:0] cv_pos;
  logic signed [TRIG_BITS+1:0] sin_next;
  logic signed [TRIG_BITS+1:0] cos_next;

  assign sv_pos = $signed({1'b0, g_sv});
  assign cv_pos = $signed({1'b0, g_cv});

  always_comb begin
    unique case (g_quad)
      rrb_pkg::QUAD_FIRST: begin
        sin_next = sv_pos;
        cos_next = cv_pos;
      end
      rrb_pkg::QUAD_SECOND: begin
        sin_next = cv_pos;
        cos_next = -sv_pos;
      end
      rrb_pkg::QUAD_THIRD: begin
        sin_next = -sv_pos;
        cos_next = -cv_pos;
      end
      default: begin
        sin_next = -cv_pos;
        cos_next = sv_pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_val  <= sin_next;
      cos_val  <= cos_next;
      out_geom <= g_geom;
    end
  end

endmodule

### rtl/core/rrb_rotate.sv
// pipelined corner rotation, min/max reduction and saturation
module rrb_rotate #(
  parameter int TRIG_BITS = rrb_pkg::DEF_TRIG_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic signed [TRIG_BITS+1:0] sin_val,
  input  logic signed [TRIG_BITS+1:0] cos_val,
  input  rrb_pkg::geom_t              in_geom,
  output logic                        out_valid,
  output rrb_pkg::box_t               out_box
);

  localparam int DX_W   = rrb_pkg::DX_W;
  localparam int SC_W   = TRIG_BITS + 2;
  localparam int PROD_W = DX_W + SC_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int COR_W  = SUM_W + 1 - TRIG_BITS;
  localparam int CW     = rrb_pkg::COORD_W;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (TRIG_BITS - 1);
  localparam logic signed [COR_W-1:0] LIM_HI   = COR_W'(rrb_pkg::COORD_MAX);
  localparam logic signed [COR_W-1:0] LIM_LO   = COR_W'(rrb_pkg::COORD_MIN);
  localparam logic [COR_W:0]          SIZE_HI  = (COR_W+1)'(rrb_pkg::SIZE_MAX);

  // corner offsets from the pivot: two distinct x and two distinct y
  logic signed [DX_W-1:0] a_dx [2];
  logic signed [DX_W-1:0] a_dy [2];
  logic signed [SC_W-1:0] a_sn;
  logic signed [SC_W-1:0] a_cs;
  logic signed [CW-1:0]   a_px;
  logic signed [CW-1:0]   a_py;
  logic                   a_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx[0] <= DX_W'(in_geom.rect_left) - DX_W'(in_geom.pivot_x);
      a_dx[1] <= DX_W'(in_geom.rect_left) + DX_W'({1'b0, in_geom.rect_width})
                 - DX_W'(in_geom.pivot_x);
      a_dy[0] <= DX_W'(in_geom.rect_top) - DX_W'(in_geom.pivot_y);
      a_dy[1] <= DX_W'(in_geom.rect_top) + DX_W'({1'b0, in_geom.rect_height})
                 - DX_W'(in_geom.pivot_y);
      a_sn    <= sin_val;
      a_cs    <= cos_val;
      a_px    <= in_geom.pivot_x;
      a_py    <= in_geom.pivot_y;
    end
  end

  // eight products of offsets with sine and cosine
  logic signed [PROD_W-1:0] b_dxc [2];
  logic signed [PROD_W-1:0] b_dxs [2];
  logic signed [PROD_W-1:0] b_dyc [2];
  logic signed [PROD_W-1:0] b_dys [2];
  logic signed [CW-1:0]     b_px;
  logic signed [CW-1:0]     b_py;
  logic                     b_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        b_dxc[k] <= a_dx[k] * a_cs;
        b_dxs[k] <= a_dx[k] * a_sn;
        b_dyc[k] <= a_dy[k] * a_cs;
        b_dys[k] <= a_dy[k] * a_sn;
      end
      b_px <= a_px;
      b_py <= a_py;
    end
  end

  // per-corner rotated sums with the rounding half
  logic signed [SUM_W-1:0] c_sx [4];
  logic signed [SUM_W-1:0] c_sy [4];
  logic signed [CW-1:0]    c_px;
  logic signed [CW-1:0]    c_py;
  logic                    c_valid;

  // corner positions relative to the pivot, pivot added back
  logic signed [COR_W-1:0] d_rx [4];
  logic signed [COR_W-1:0] d_ry [4];
  logic                    d_valid;

  for (genvar i = 0; i < 4; i++) begin : g_corner
    localparam int AX = (i == 1 || i == 2) ? 1 : 0;
    localparam int BY = (i >= 2) ? 1 : 0;

    logic signed [SUM_W:0] fx;
    logic signed [SUM_W:0] fy;

    always_ff @(posedge clk) begin
      if (adv) begin
        c_sx[i] <= SUM_W'(b_dxc[AX]) - SUM_W'(b_dys[BY]) + RND_HALF;
        c_sy[i] <= SUM_W'(b_dxs[AX]) + SUM_W'(b_dyc[BY]) + RND_HALF;
      end
    end

    // pivot scaled into the product fraction, then shifted down
    assign fx = (SUM_W+1)'(c_sx[i]) + ((SUM_W+1)'(c_px) <<< TRIG_BITS);
    assign fy = (SUM_W+1)'(c_sy[i]) + ((SUM_W+1)'(c_py) <<< TRIG_BITS);

    always_ff @(posedge clk) begin
      if (adv) begin
        d_rx[i] <= fx[SUM_W:TRIG_BITS];
        d_ry[i] <= fy[SUM_W:TRIG_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_px <= b_px;
      c_py <= b_py;
    end
  end

  // pairwise min and max
  logic signed [COR_W-1:0] e_lox [2];
  logic signed [COR_W-1:0] e_hix [2];
  logic signed [COR_W-1:0] e_loy [2];
  logic signed [COR_W-1:0] e_hiy [2];
  logic                    e_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        e_lox[k] <= (d_rx[2*k] < d_rx[2*k+1]) ? d_rx[2*k] : d_rx[2*k+1];
        e_hix[k] <= (d_rx[2*k] > d_rx[2*k+1]) ? d_rx[2*k] : d_rx[2*k+1];
        e_loy[k] <= (d_ry[2*k] < d_ry[2*k+1]) ? d_ry[2*k] : d_ry[2*k+1];
        e_hiy[k] <= (d_ry[2*k] > d_ry[2*k+1]) ? d_ry[2*k] : d_ry[2*k+1];
      end
    end
  end

  // final extremes
  logic signed [COR_W-1:0] f_minx;
  logic signed [COR_W-1:0] f_maxx;
  logic signed [COR_W-1:0] f_miny;
  logic signed [COR_W-1:0] f_maxy;
  logic                    f_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_minx <= (e_lox[0] < e_lox[1]) ? e_lox[0] : e_lox[1];
      f_maxx <= (e_hix[0] > e_hix[1]) ? e_hix[0] : e_hix[1];
      f_miny <= (e_loy[0] < e_loy[1]) ? e_loy[0] : e_loy[1];
      f_maxy <= (e_hiy[0] > e_hiy[1]) ? e_hiy[0] : e_hiy[1];
    end
  end

  // saturation of the corner and the extents
  logic [COR_W:0]      span_x;
  logic [COR_W:0]      span_y;
  rrb_pkg::box_t       box_next;

  assign span_x = (COR_W+1)'(f_maxx) - (COR_W+1)'(f_minx);
  assign span_y = (COR_W+1)'(f_maxy) - (COR_W+1)'(f_miny);

  always_comb begin
    if (f_minx > LIM_HI) begin
      box_next.box_left = LIM_HI[CW-1:0];
    end else if (f_minx < LIM_LO) begin
      box_next.box_left = LIM_LO[CW-1:0];
    end else begin
      box_next.box_left = f_minx[CW-1:0];
    end
    if (f_miny > LIM_HI) begin
      box_next.box_top = LIM_HI[CW-1:0];
    end else if (f_miny < LIM_LO) begin
      box_next.box_top = LIM_LO[CW-1:0];
    end else begin
      box_next.box_top = f_miny[CW-1:0];
    end
    box_next.box_width  = (span_x > SIZE_HI) ? SIZE_HI[rrb_pkg::SIZE_W-1:0]
                                             : span_x[rrb_pkg::SIZE_W-1:0];
    box_next.box_height = (span_y > SIZE_HI) ? SIZE_HI[rrb_pkg::SIZE_W-1:0]
                                             : span_y[rrb_pkg::SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_box <= box_next;
    end
  end

endmodule

### rtl/core/rrb_out_buf.sv
// two-entry result buffer between the pipeline and the output channel
module rrb_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rrb_pkg::box_t push_box,
  output logic          full,
  rrb_out_if.source     box_out
);

  rrb_pkg::box_t ent [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic [1:0]    count_next;
  logic          pop;

  assign pop  = box_out.valid && box_out.ready;
  assign full = (count == 2'd2);

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = 2'(count + 2'd1);
    end else if (!push && pop) begin
      count_next = 2'(count - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_box;
    end
  end

  // output transaction
  assign box_out.valid      = (count != 2'd0);
  assign box_out.box_left   = ent[rd_ptr].box_left;
  assign box_out.box_top    = ent[rd_ptr].box_top;
  assign box_out.box_width  = ent[rd_ptr].box_width;
  assign box_out.box_height = ent[rd_ptr].box_height;

endmodule

### rtl/core/rotated_rect_bounds_core.sv
// top level of the rotated rectangle bounding box core
// Rotates the four corners of an axis-aligned rectangle about a pivot by a
// binary angle (2^ANGLE_BITS units per turn) and returns the enclosing
// axis-aligned box as its minimum corner plus width and height, saturated.
// Sine and cosine come from a Taylor series evaluated in a 43-stage pipeline
// (one multiply, one reciprocal multiply and one remainder correction per
// term), followed by a 7-stage rotate and min/max pipeline and a two-entry
// result buffer. One transaction is accepted every clock cycle while ready
// is high. The input is held off only when two results wait in the buffer
// and a third has reached the pipeline end; ready does not depend
// combinationally on the output side.
module rotated_rect_bounds_core #(
  parameter int ANGLE_BITS = rrb_pkg::DEF_ANGLE_BITS,
  parameter int TRIG_BITS  = rrb_pkg::DEF_TRIG_BITS
) (
  input  logic      clk,
  input  logic      rst,
  rrb_in_if.sink    rect_in,
  rrb_out_if.source box_out
);

  logic                        adv;
  logic                        buf_full;
  rrb_pkg::geom_t              in_geom;
  logic                        trig_valid;
  logic signed [TRIG_BITS+1:0] trig_sin;
  logic signed [TRIG_BITS+1:0] trig_cos;
  rrb_pkg::geom_t              trig_geom;
  logic                        rot_valid;
  rrb_pkg::box_t               rot_box;

  // whole pipeline moves unless the buffer cannot take the last stage
  assign adv           = !(buf_full && rot_valid);
  assign rect_in.ready = adv;

  // input transaction payload
  assign in_geom.rect_left   = rect_in.rect_left;
  assign in_geom.rect_top    = rect_in.rect_top;
  assign in_geom.rect_width  = rect_in.rect_width;
  assign in_geom.rect_height = rect_in.rect_height;
  assign in_geom.pivot_x     = rect_in.pivot_x;
  assign in_geom.pivot_y     = rect_in.pivot_y;

  rrb_trig #(
    .ANGLE_BITS (ANGLE_BITS),
    .TRIG_BITS  (TRIG_BITS)
  ) u_trig (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (rect_in.valid),
    .angle     (rect_in.turn_angle),
    .in_geom   (in_geom),
    .out_valid (trig_valid),
    .sin_val   (trig_sin),
    .cos_val   (trig_cos),
    .out_geom  (trig_geom)
  );

  rrb_rotate #(
    .TRIG_BITS (TRIG_BITS)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (trig_valid),
    .sin_val   (trig_sin),
    .cos_val   (trig_cos),
    .in_geom   (trig_geom),
    .out_valid (rot_valid),
    .out_box   (rot_box)
  );

  rrb_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (adv && rot_valid),
    .push_box (rot_box),
    .full     (buf_full),
    .box_out  (box_out)
  );

endmodule
